FILE: hw/rtl/date_offset_by_days_assert.svh
// Assertion macros for the date offset block.
`ifndef DATE_OFFSET_BY_DAYS_ASSERT_SVH
`define DATE_OFFSET_BY_DAYS_ASSERT_SVH

`ifndef SYNTH

// cond at this edge requires prop at the same edge
`define DOBD_ASSERT_SAME(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("date_offset_by_days: same-cycle check failed");

// cond at this edge requires prop at the next edge
`define DOBD_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("date_offset_by_days: next-cycle check failed");

`else

`define DOBD_ASSERT_SAME(label, clk, rst, cond, prop)
`define DOBD_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

FILE: hw/rtl/dobd_pkg.sv
package dobd_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int COUNT_W = 20;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  localparam int REM_W  = 22;  // signed day remainder
  localparam int BASE_W = 16;  // signed year accumulator
  localparam int YOE_W  = 9;   // year within a 400-year cycle
  localparam int DOE_W  = 18;  // day within a 400-year cycle

  localparam int YEAR_LIMIT = 9999;
  localparam int ERA_YEARS  = 400;
  localparam int BIG_YEARS  = 3200;
  localparam int CENT_YEARS = 100;
  localparam int QUAD_YEARS = 4;

  localparam int ERA_DAYS  = 146097;
  localparam int CENT_DAYS = 36524;
  localparam int QUAD_DAYS = 1461;
  localparam int YEAR_DAYS = 365;

  localparam logic [1:0] LAST_CENT = 2'd3;
  localparam logic [4:0] LAST_QUAD = 5'd24;
  localparam logic [1:0] LAST_YEAR = 2'd3;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // Month index counted from March: March is 0, January 10, February 11.
  localparam logic [MONTH_W-1:0] MAR_JAN = 4'd10;
  localparam logic [MONTH_W-1:0] MAR_FEB = 4'd11;
  localparam logic [MONTH_W-1:0] MAR_OFS = 4'd3;
  localparam logic [MONTH_W-1:0] JAN_OFS = 4'd9;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_BIG,
    ST_RED,
    ST_ZCALC,
    ST_ERA,
    ST_CENT,
    ST_QUAD,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RED_BIG,
    CMD_RED,
    CMD_PREP,
    CMD_ZCALC,
    CMD_WRAP_UP,
    CMD_WRAP_DOWN,
    CMD_CENT,
    CMD_QUAD,
    CMD_YEAR,
    CMD_MONTH,
    CMD_OUT
  } cmd_t;

  typedef struct packed {
    logic ge_big;
    logic ge_era;
    logic rem_neg;
    logic rem_ge_era;
    logic cent_ge;
    logic quad_ge;
    logic year_ge;
    logic month_ge;
    logic out_free;
  } stat_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    begin
      case (m) inside
        MONTH_FEB: len = leap ? 5'd29 : 5'd28;
        MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
        default: len = 5'd31;
      endcase
      return len;
    end
  endfunction

  // Length of a month counted from March; February is never stepped over.
  function automatic logic [DAY_W-1:0] mar_len(input logic [MONTH_W-1:0] mp);
    logic [DAY_W-1:0] len;
    begin
      case (mp) inside
        4'd1, 4'd3, 4'd6, 4'd8: len = 5'd30;
        MAR_FEB: len = 5'd29;
        default: len = 5'd31;
      endcase
      return len;
    end
  endfunction

  // First day of a month within the March-based year.
  function automatic logic [YOE_W-1:0] mar_start(input logic [MONTH_W-1:0] mp);
    logic [YOE_W-1:0] ofs;
    begin
      case (mp)
        4'd0:  ofs = 9'd0;
        4'd1:  ofs = 9'd31;
        4'd2:  ofs = 9'd61;
        4'd3:  ofs = 9'd92;
        4'd4:  ofs = 9'd122;
        4'd5:  ofs = 9'd153;
        4'd6:  ofs = 9'd184;
        4'd7:  ofs = 9'd214;
        4'd8:  ofs = 9'd245;
        4'd9:  ofs = 9'd275;
        4'd10: ofs = 9'd306;
        4'd11: ofs = 9'd337;
        default: ofs = 9'd0;
      endcase
      return ofs;
    end
  endfunction

endpackage

FILE: hw/rtl/dobd_ctrl.sv
module dobd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  dobd_pkg::stat_t stat,
  output dobd_pkg::cmd_t  cmd
);
  import dobd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = ST_RED_BIG;
        end
      end
      ST_RED_BIG: begin
        if (stat.ge_big) begin
          cmd = CMD_RED_BIG;
        end else begin
          state_next = ST_RED;
        end
      end
      ST_RED: begin
        if (stat.ge_era) begin
          cmd = CMD_RED;
        end else begin
          cmd        = CMD_PREP;
          state_next = ST_ZCALC;
        end
      end
      ST_ZCALC: begin
        cmd        = CMD_ZCALC;
        state_next = ST_ERA;
      end
      ST_ERA: begin
        if (stat.rem_neg) begin
          cmd = CMD_WRAP_UP;
        end else if (stat.rem_ge_era) begin
          cmd = CMD_WRAP_DOWN;
        end else begin
          state_next = ST_CENT;
        end
      end
      ST_CENT: begin
        if (stat.cent_ge) begin
          cmd = CMD_CENT;
        end else begin
          state_next = ST_QUAD;
        end
      end
      ST_QUAD: begin
        if (stat.quad_ge) begin
          cmd = CMD_QUAD;
        end else begin
          state_next = ST_YEAR;
        end
      end
      ST_YEAR: begin
        if (stat.year_ge) begin
          cmd = CMD_YEAR;
        end else begin
          state_next = ST_MONTH;
        end
      end
      ST_MONTH: begin
        if (stat.month_ge) begin
          cmd = CMD_MONTH;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd        = CMD_OUT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/dobd_dp.sv
module dobd_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  dobd_pkg::cmd_t                  cmd,
  output dobd_pkg::stat_t                 stat,
  input  logic [dobd_pkg::IN_DATA_W-1:0]  in_data,
  input  logic                            in_user,
  output logic [dobd_pkg::OUT_DATA_W-1:0] out_data,
  output logic                            out_user,
  output logic                            out_valid,
  input  logic                            out_ready
);
  import dobd_pkg::*;

  logic                   op;
  logic [COUNT_W-1:0]     count;
  logic [MONTH_W-1:0]     month;
  logic [DAY_W-1:0]       day;
  logic [YEAR_W-1:0]      ym;
  logic [BASE_W-1:0]      base;
  logic [YOE_W-1:0]       yoe;
  logic [YOE_W-1:0]       doy;
  logic [REM_W-1:0]       rem;
  logic [1:0]             cent;
  logic [4:0]             quad;
  logic [1:0]             yr;
  logic [MONTH_W-1:0]     mp;
  logic [YEAR_W-1:0]      out_year;
  logic [MONTH_W-1:0]     out_month;
  logic [DAY_W-1:0]       out_day;

  logic [YEAR_W-1:0]      in_year;
  logic [MONTH_W-1:0]     in_month;
  logic [DAY_W-1:0]       in_day;
  logic [COUNT_W-1:0]     in_count;
  logic [MONTH_W-1:0]     in_month_v;

  logic [YOE_W-1:0]       ym9;
  logic                   leap;
  logic [DAY_W-1:0]       mlen;
  logic [DAY_W-1:0]       day_v;
  logic                   early;
  logic [MONTH_W-1:0]     mp_v;
  logic [YOE_W-1:0]       doy_v;
  logic [YOE_W-1:0]       yoe_v;
  logic                   wrap_v;

  logic [1:0]             yoe_cent;
  logic [DOE_W-1:0]       doe;
  logic [REM_W-1:0]       rem_v;

  logic [BASE_W-1:0]      year_f;
  logic [YEAR_W-1:0]      year_sat;
  logic                   err_v;
  logic [MONTH_W-1:0]     month_f;

  assign in_year  = in_data[13:0];
  assign in_month = in_data[17:14];
  assign in_day   = in_data[22:18];
  assign in_count = in_data[42:23];

  assign in_month_v = (in_month < MONTH_JAN || in_month > MONTH_DEC) ? MONTH_JAN : in_month;

  // Start date into March-based year and day of year; year below 400 by now.
  always_comb begin
    ym9    = ym[YOE_W-1:0];
    leap   = (ym9[1:0] == 2'd0) && (ym9 != 9'd100) && (ym9 != 9'd200) && (ym9 != 9'd300);
    mlen   = month_len(month, leap);
    day_v  = (day == '0 || day > mlen) ? 5'd1 : day;
    early  = (month <= MONTH_FEB);
    mp_v   = early ? month + JAN_OFS : month - MAR_OFS;
    doy_v  = mar_start(mp_v) + YOE_W'(day_v) - 9'd1;
    wrap_v = early && (ym9 == '0);
    if (!early) begin
      yoe_v = ym9;
    end else if (wrap_v) begin
      yoe_v = YOE_W'(ERA_YEARS - 1);
    end else begin
      yoe_v = ym9 - 9'd1;
    end
  end

  // Day within the 400-year cycle, then offset by the count.
  always_comb begin
    if (yoe >= 9'd300) begin
      yoe_cent = 2'd3;
    end else if (yoe >= 9'd200) begin
      yoe_cent = 2'd2;
    end else if (yoe >= 9'd100) begin
      yoe_cent = 2'd1;
    end else begin
      yoe_cent = 2'd0;
    end
    doe = DOE_W'(yoe) * DOE_W'(YEAR_DAYS) + DOE_W'(yoe[YOE_W-1:2])
        - DOE_W'(yoe_cent) + DOE_W'(doy);
    if (op) begin
      rem_v = REM_W'(doe) - REM_W'(count);
    end else begin
      rem_v = REM_W'(doe) + REM_W'(count);
    end
  end

  always_comb begin
    year_f  = base + BASE_W'(mp >= MAR_JAN);
    month_f = (mp < MAR_JAN) ? mp + MAR_OFS : mp - JAN_OFS;
    if (year_f[BASE_W-1]) begin
      year_sat = '0;
      err_v    = 1'b1;
    end else if (year_f > BASE_W'(YEAR_LIMIT)) begin
      year_sat = YEAR_W'(YEAR_LIMIT);
      err_v    = 1'b1;
    end else begin
      year_sat = year_f[YEAR_W-1:0];
      err_v    = 1'b0;
    end
  end

  always_comb begin
    stat.ge_big     = (ym >= YEAR_W'(BIG_YEARS));
    stat.ge_era     = (ym >= YEAR_W'(ERA_YEARS));
    stat.rem_neg    = rem[REM_W-1];
    stat.rem_ge_era = !rem[REM_W-1] && (rem >= REM_W'(ERA_DAYS));
    stat.cent_ge    = (cent != LAST_CENT) && (rem >= REM_W'(CENT_DAYS));
    stat.quad_ge    = (quad != LAST_QUAD) && (rem >= REM_W'(QUAD_DAYS));
    stat.year_ge    = (yr != LAST_YEAR) && (rem >= REM_W'(YEAR_DAYS));
    stat.month_ge   = (mp != MAR_FEB) && (rem >= REM_W'(mar_len(mp)));
    stat.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        op    <= in_user;
        count <= in_count;
        month <= in_month_v;
        day   <= in_day;
        ym    <= in_year;
        base  <= '0;
      end
      CMD_RED_BIG: begin
        ym   <= ym - YEAR_W'(BIG_YEARS);
        base <= base + BASE_W'(BIG_YEARS);
      end
      CMD_RED: begin
        ym   <= ym - YEAR_W'(ERA_YEARS);
        base <= base + BASE_W'(ERA_YEARS);
      end
      CMD_PREP: begin
        yoe <= yoe_v;
        doy <= doy_v;
        if (wrap_v) begin
          base <= base - BASE_W'(ERA_YEARS);
        end
      end
      CMD_ZCALC: begin
        rem  <= rem_v;
        cent <= '0;
        quad <= '0;
        yr   <= '0;
        mp   <= '0;
      end
      CMD_WRAP_UP: begin
        rem  <= rem + REM_W'(ERA_DAYS);
        base <= base - BASE_W'(ERA_YEARS);
      end
      CMD_WRAP_DOWN: begin
        rem  <= rem - REM_W'(ERA_DAYS);
        base <= base + BASE_W'(ERA_YEARS);
      end
      CMD_CENT: begin
        rem  <= rem - REM_W'(CENT_DAYS);
        base <= base + BASE_W'(CENT_YEARS);
        cent <= cent + 2'd1;
      end
      CMD_QUAD: begin
        rem  <= rem - REM_W'(QUAD_DAYS);
        base <= base + BASE_W'(QUAD_YEARS);
        quad <= quad + 5'd1;
      end
      CMD_YEAR: begin
        rem  <= rem - REM_W'(YEAR_DAYS);
        base <= base + BASE_W'(1);
        yr   <= yr + 2'd1;
      end
      CMD_MONTH: begin
        rem <= rem - REM_W'(mar_len(mp));
        mp  <= mp + 4'd1;
      end
      CMD_OUT: begin
        out_year  <= year_sat;
        out_month <= month_f;
        out_day   <= rem[DAY_W-1:0] + 5'd1;
        out_user  <= err_v;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == CMD_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_data = {1'b0, out_day, out_month, out_year};

endmodule

FILE: hw/rtl/date_offset_by_days.sv
// Gregorian date plus or minus a day count. A word on the input carries a
// start date and a count of up to 1048575 days; tuser picks add (0) or
// subtract (1). A month outside 1..12 is taken as January, a day of 0 or past
// the end of its month as the 1st. One result word comes back per input word;
// a year that leaves 0..9999 is clamped and flagged in tuser. The date is
// walked by a step sequencer over one shared remainder register: the start
// year is cut to its 400-year cycle (steps of 3200 and then of 400 years, up
// to 11 in all), the remainder is folded into one 400-year cycle (up to 8
// steps), then peeled off by centuries (up to 3), 4-year blocks (up to 24),
// years (up to 3) and months (up to 11), one step a cycle. The next word is
// accepted in the cycle after the result is loaded, even while that result
// still waits on the output.
`include "date_offset_by_days_assert.svh"

module date_offset_by_days (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // start_year[13:0], start_month[17:14], start_day[22:18], day_count[42:23]
  input  logic [dobd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // operation[0]
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // result_year[13:0], result_month[17:14], result_day[22:18]
  output logic [dobd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // range_error[0]
  output logic                            m_axis_tuser
);
  import dobd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  dobd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dobd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready)
  );

  `DOBD_ASSERT_SAME(a_month_range, clk, rst, m_axis_tvalid,
                    (m_axis_tdata[17:14] >= 4'd1 && m_axis_tdata[17:14] <= 4'd12))
  `DOBD_ASSERT_SAME(a_clamp_edge, clk, rst, m_axis_tvalid && m_axis_tuser,
                    (m_axis_tdata[13:0] == 14'd0 || m_axis_tdata[13:0] == 14'd9999))
  `DOBD_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_axis_tvalid && s_axis_tready,
                    !s_axis_tready)
  `DOBD_ASSERT_NEXT(a_result_loaded, clk, rst, cmd == CMD_OUT, m_axis_tvalid)

endmodule
